// ===== sv/e8e9sd_pkg.sv =====
// Package for the E8/E9 call and jump address decoder.
// Holds the output queue entry type and the pattern constants; no dependencies.
`default_nettype none

package e8e9sd_pkg;

  localparam int unsigned WIN_LEN = 6;
  localparam int unsigned QUE_LEN = 7;
  localparam int unsigned HDR_LEN = 4;

  localparam logic [7:0] OP_CALL  = 8'hE8;
  localparam logic [7:0] OP_JMP   = 8'hE9;
  localparam logic [7:0] OP_ESC   = 8'h0F;
  localparam logic [3:0] OP_JCC   = 4'h8;
  localparam logic [7:0] TAIL_POS = 8'h00;
  localparam logic [7:0] TAIL_NEG = 8'hFF;
  localparam logic [7:0] ADDR_XOR = 8'hB0;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } beat_t;

endpackage

`default_nettype wire

// ===== sv/e8e9_stream_decode.sv =====
// Top level of the E8/E9 call and jump address decoder.
// Uses e8e9sd_pkg for the queue entry type and the opcode constants.
//
//   channel | dir | tdata fields (low bit up) | tlast
//   in_     | in  | byte [7:0]                | last byte of stream
//   out_    | out | byte [7:0]                | last decoded byte
//
// An input transaction is decoded in the cycle it is accepted and its results
// land in a seven-entry output queue, so one byte is taken every cycle while
// the consumer keeps up. in_tready is high while the queue holds at most one
// entry; a final byte can push up to six entries, which drain one a cycle
// while the consumer keeps up. Reset is synchronous and active low and clears
// the header, window and queue counters; there is no clearing pass.
`default_nettype none

module e8e9_stream_decode
  import e8e9sd_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = 65536
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // byte [7:0]
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // byte [7:0]
  output logic            out_tlast
);

  localparam int unsigned BLKW = $clog2(BLOCK_BYTES);

  logic [2:0]      hdr_r, hdr_nxt;
  logic [16:0]     base_r, base_nxt;
  logic [24:0]     off_r, off_nxt;
  logic [2:0]      fill_r, fill_nxt;
  logic [31:0]     pos_r, pos_nxt;
  logic [BLKW-1:0] blk_r, blk_nxt;
  logic [7:0]      win_r [WIN_LEN];
  logic [7:0]      win_nxt [WIN_LEN];
  beat_t           que_r [QUE_LEN];
  beat_t           que_nxt [QUE_LEN];
  logic [2:0]      cnt_r, cnt_nxt;

  logic        acc, pop, hdr_done, full, hit;
  logic        tail_ok, op_ok, in_blk;
  logic [7:0]  wn [WIN_LEN];
  logic [7:0]  wd [WIN_LEN];
  logic [24:0] addr, xd, hdr_base;
  logic [2:0]  fill_up, n, start, cp, sel;
  beat_t       pl [WIN_LEN];

  assign in_tready  = (cnt_r <= 3'd1);
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = que_r[0].data;
  assign out_tlast  = que_r[0].last;

  always_comb begin
    acc      = in_tvalid && in_tready;
    pop      = out_tvalid && out_tready;
    hdr_done = (hdr_r == 3'(HDR_LEN));
    full     = (fill_r == 3'd5);
    fill_up  = full ? 3'd5 : fill_r + 3'd1;
    hdr_base = {base_r, in_tdata};

    wn[0] = in_tdata;
    for (int i = 1; i < WIN_LEN; i++) begin
      wn[i] = win_r[i-1];
    end

    tail_ok = (wn[0] == TAIL_POS) || (wn[0] == TAIL_NEG);
    op_ok   = (wn[4] == OP_CALL) || (wn[4] == OP_JMP) ||
              ((wn[5] == OP_ESC) && (wn[4][7:4] == OP_JCC));
    in_blk  = (blk_r >= BLKW'(5));
    hit     = full && tail_ok && op_ok && in_blk;
    addr    = {wn[0][0], wn[3] ^ ADDR_XOR, wn[2] ^ ADDR_XOR, wn[1] ^ ADDR_XOR};
    xd      = addr - off_r;

    wd = wn;
    if (hit) begin
      wd[3] = xd[7:0];
      wd[2] = xd[15:8];
      wd[1] = xd[23:16];
      wd[0] = {8{xd[24]}};
    end

    if (acc && hdr_done) begin
      n = (full ? 3'd1 : 3'd0) + (in_tlast ? fill_up : 3'd0);
    end else begin
      n = 3'd0;
    end
    start = full ? 3'd0 : 3'd6 - fill_up;

    for (int j = 0; j < WIN_LEN; j++) begin
      sel = start + 3'(j);
      pl[j].data = 8'h00;
      for (int k = 0; k < WIN_LEN; k++) begin
        if (sel == 3'(k)) begin
          pl[j].data = wd[WIN_LEN-1-k];
        end
      end
      pl[j].last = in_tlast && (3'(j) == n - 3'd1);
    end

    cp = cnt_r - (pop ? 3'd1 : 3'd0);
    for (int i = 0; i < QUE_LEN; i++) begin
      if (pop && (i < QUE_LEN - 1)) begin
        que_nxt[i] = que_r[i+1];
      end else begin
        que_nxt[i] = que_r[i];
      end
      for (int j = 0; j < WIN_LEN; j++) begin
        if (({1'b0, cp} + 4'(j) == 4'(i)) && (3'(j) < n)) begin
          que_nxt[i] = pl[j];
        end
      end
    end
    cnt_nxt = cp + n;

    hdr_nxt  = hdr_r;
    base_nxt = base_r;
    off_nxt  = off_r;
    fill_nxt = fill_r;
    pos_nxt  = pos_r;
    blk_nxt  = blk_r;
    win_nxt  = win_r;
    if (acc) begin
      if (!hdr_done) begin
        base_nxt = hdr_base[16:0];
        hdr_nxt  = hdr_r + 3'd1;
        if (hdr_r == 3'(HDR_LEN - 1)) begin
          off_nxt = hdr_base + 25'd1;
        end
      end else begin
        win_nxt  = wd;
        fill_nxt = fill_up;
        pos_nxt  = pos_r + 32'd1;
        off_nxt  = off_r + 25'd1;
        if ((blk_r == BLKW'(BLOCK_BYTES - 1)) || (pos_r == 32'hFFFF_FFFF)) begin
          blk_nxt = '0;
        end else begin
          blk_nxt = blk_r + BLKW'(1);
        end
      end
      if (in_tlast) begin
        hdr_nxt  = 3'd0;
        fill_nxt = 3'd0;
        pos_nxt  = 32'd0;
        blk_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= 3'd0;
      fill_r <= 3'd0;
      pos_r  <= 32'd0;
      blk_r  <= '0;
      cnt_r  <= 3'd0;
    end else begin
      hdr_r  <= hdr_nxt;
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
      blk_r  <= blk_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    off_r  <= off_nxt;
    win_r  <= win_nxt;
    que_r  <= que_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/e8e9sd_checker.sv =====
// Port-level checker for the E8/E9 call and jump address decoder.
// Sees only the top-level ports and is bound to e8e9_stream_decode below.
`default_nettype none

module e8e9sd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       in_tlast,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("Stalled output transaction changed.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Output valid right after reset.");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("Input stalled while no output is pending.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready) |=> !out_tvalid)
    else $error("Output appeared without an input transaction.");

endmodule

bind e8e9_stream_decode e8e9sd_checker u_e8e9sd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tlast  (in_tlast),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

`default_nettype wire

// ===== test/tb_e8e9_stream_decode.sv =====
// Self-checking testbench for e8e9_stream_decode, the E8/E9 call and jump address decoder.
// It feeds byte streams under random stalls and checks every decoded byte against its own
// predictor. Depends on e8e9sd_pkg and the e8e9_stream_decode top level.
`default_nettype none

module tb_e8e9_stream_decode
  import e8e9sd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BLK_BYTES   = 65536;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned RAND_ITEMS  = 400;
  localparam int unsigned DRAIN_WAIT  = 16;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;  // byte [7:0]
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata; // byte [7:0]
  logic       out_tlast;

  e8e9_stream_decode #(.BLOCK_BYTES(BLK_BYTES)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  beat_t       pending_bytes[$];
  beat_t       decoded_due[$];
  logic [7:0]  stream_data[$];

  int unsigned hdr_taken;
  logic [31:0] base_addr;
  logic [7:0]  window[WIN_LEN];
  int unsigned win_fill;
  logic [31:0] data_pos;

  logic        in_fire;
  int unsigned in_gap;
  int unsigned out_stall;
  logic        calm;
  int unsigned idle_cycles;
  int unsigned errors;
  beat_t       next_item;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_stream();
    hdr_taken = 0;
    base_addr = '0;
    foreach (window[k]) window[k] = '0;
    win_fill  = 0;
    data_pos  = '0;
  endfunction

  function automatic void patch_call_address();
    logic [31:0] x;
    logic        tail_ok;
    logic        op_ok;
    logic        in_block;
    tail_ok  = (window[0] == TAIL_POS) || (window[0] == TAIL_NEG);
    op_ok    = (window[4] == OP_CALL) || (window[4] == OP_JMP) ||
               ((window[5] == OP_ESC) && (window[4][7:4] == OP_JCC));
    in_block = (data_pos % 32'(BLK_BYTES)) >= 32'd5;
    if (tail_ok && op_ok && in_block) begin
      x = {window[0], window[3] ^ ADDR_XOR, window[2] ^ ADDR_XOR, window[1] ^ ADDR_XOR};
      x = x - (data_pos + 32'd1) - base_addr;
      x = {{7{x[24]}}, x[24:0]};
      window[3] = x[7:0];
      window[2] = x[15:8];
      window[1] = x[23:16];
      window[0] = x[31:24];
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    int k;
    int n;
    n = 0;
    if (hdr_taken < HDR_LEN) begin
      base_addr = {base_addr[23:0], b};
      hdr_taken++;
      if (last) clear_stream();
      return;
    end
    for (k = WIN_LEN - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    if (win_fill >= WIN_LEN - 1) begin
      patch_call_address();
      decoded_due.push_back('{last: 1'b0, data: window[WIN_LEN-1]});
      n++;
    end else begin
      win_fill++;
    end
    data_pos++;
    if (last) begin
      for (k = int'(win_fill) - 1; k >= 0; k--) begin
        decoded_due.push_back('{last: 1'b0, data: window[k]});
        n++;
      end
      if (n > 0) decoded_due[$].last = 1'b1;
      clear_stream();
    end
  endfunction

  task automatic add_stream(logic [31:0] base, int unsigned hdr_len);
    int unsigned k;
    int unsigned total;
    total = hdr_len + stream_data.size();
    for (k = 0; k < hdr_len; k++)
      pending_bytes.push_back('{last: (k + 1 == total), data: base[31 - 8*k -: 8]});
    for (k = 0; k < stream_data.size(); k++)
      pending_bytes.push_back('{last: (hdr_len + k + 1 == total), data: stream_data[k]});
    stream_data.delete();
  endtask

  function automatic logic [7:0] loaded_byte();
    case ($urandom_range(0, 7))
      0: return OP_CALL;
      1: return OP_JMP;
      2: return OP_ESC;
      3: return TAIL_POS;
      4: return TAIL_NEG;
      5: return {OP_JCC, 4'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic fill_random(int unsigned n);
    int unsigned left;
    int unsigned k;
    left = n;
    while (left > 0) begin
      if (left >= 6 && $urandom_range(0, 9) < 4) begin
        case ($urandom_range(0, 2))
          0: stream_data.push_back(OP_CALL);
          1: stream_data.push_back(OP_JMP);
          default: begin
            stream_data.push_back(OP_ESC);
            stream_data.push_back({OP_JCC, 4'($urandom)});
            left--;
          end
        endcase
        for (k = 0; k < 3; k++) stream_data.push_back(8'($urandom));
        case ($urandom_range(0, 4))
          0: stream_data.push_back(8'($urandom));
          1, 2: stream_data.push_back(TAIL_POS);
          default: stream_data.push_back(TAIL_NEG);
        endcase
        left -= 5;
      end else begin
        stream_data.push_back(($urandom_range(0, 99) < 15) ? loaded_byte() : 8'($urandom));
        left--;
      end
    end
  endtask

  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (decoded_due.size() == 0) begin
          if (errors < 10)
            $display("ERROR: unexpected output byte %02h last %0b", out_tdata, out_tlast);
          errors++;
        end else begin
          next_item = decoded_due.pop_front();
          if (out_tdata !== next_item.data || out_tlast !== next_item.last) begin
            if (errors < 10)
              $display("ERROR: output byte %02h last %0b, expected byte %02h last %0b",
                       out_tdata, out_tlast, next_item.data, next_item.last);
            errors++;
          end
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_item = pending_bytes.pop_front();
          in_tdata  <= next_item.data;
          in_tlast  <= next_item.last;
          in_tvalid <= 1'b1;
          in_gap     = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall   = pick_gap();
      end
      if ($urandom_range(0, 199) == 0) calm = ~calm;
    end
  end

  initial begin
    logic [31:0] base;
    int unsigned r;
    int unsigned k;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    in_fire     = 1'b0;
    in_gap      = 0;
    out_stall   = 0;
    calm        = 1'b0;
    idle_cycles = 0;
    errors      = 0;
    clear_stream();

    add_stream(32'hA500_0000, 1);
    add_stream(32'hFFFF_FFFF, HDR_LEN);
    stream_data = '{8'h00, 8'hFF, 8'h5A};
    add_stream(32'h0000_0000, HDR_LEN);
    stream_data = '{8'h7F};
    add_stream(32'h1234_5678, HDR_LEN);
    stream_data = '{8'h90, OP_CALL, 8'h12, 8'h34, 8'h56, TAIL_POS,
                    OP_JMP, 8'hAB, 8'hCD, 8'hEF, TAIL_NEG,
                    OP_ESC, 8'h85, 8'h01, 8'h02, 8'h03, TAIL_POS,
                    OP_ESC, 8'h8F, 8'hFF, 8'hFF, 8'hFF, TAIL_NEG, 8'h90};
    add_stream(32'h0000_0000, HDR_LEN);
    stream_data = '{OP_CALL, 8'h00, 8'h00, 8'h00, TAIL_NEG, 8'h90, OP_JMP,
                    8'hB0, 8'hB0, 8'hB0, TAIL_POS};
    add_stream(32'hFFFF_FFFF, HDR_LEN);

    k = pending_bytes.size();
    while (pending_bytes.size() < k + RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      base = (r < 10) ? 32'h0 : (r < 20) ? 32'hFFFF_FFFF : $urandom;
      if ($urandom_range(0, 11) == 0) begin
        add_stream(base, $urandom_range(1, HDR_LEN));
      end else begin
        fill_random(($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(0, 40));
        add_stream(base, HDR_LEN);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
